>>> rtl/core/arpm_pkg.sv
// ----------------------------------------------------------------------------
// arpm_pkg
// Shared types and constants for the ARP binding monitor.
// ----------------------------------------------------------------------------
package arpm_pkg;

  localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
  localparam logic [15:0] ARP_OP_REPLY  = 16'd2;

  typedef struct packed {
    logic [15:0] eth_type;
    logic [15:0] arp_opcode;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
  } in_item_t;

  typedef struct packed {
    logic        spoof_alert;
    logic [47:0] previous_mac;
    logic        learned_new;
    logic        table_full_drop;
  } out_item_t;

  // One binding as stored in the table memory.
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

>>> rtl/core/arpm_ram.sv
// ----------------------------------------------------------------------------
// arpm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module arpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/arp_spoof_monitor.sv
// ----------------------------------------------------------------------------
// arp_spoof_monitor
// ARP reply binding monitor: learns IPv4-to-MAC bindings, flags rebinds.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_data and raise start; a transaction is taken at
//   the rising edge where start is high and busy is low.
//   Result channel: out_valid is high for exactly one cycle with out_data;
//   the receiver cannot stall, so sample it on that cycle.
//   Frames that are not ARP replies finish at once: the result shows in the
//   cycle after the transaction and busy never rises.
//   ARP replies scan the binding table, one entry per cycle through the read
//   port of the table RAM, in fill order. A miss compares every stored
//   binding before the result shows; a hit stops the scan at the matching
//   entry. The scan is linear; one item is worked on at a time.
//   The table fills from entry 0 upward and is never emptied, so a fill
//   count marks which entries are live; reset clears the count and no
//   clearing pass over the RAM is needed.
//   Reset (rst_n low, synchronous) returns to idle with an empty table.
// ----------------------------------------------------------------------------
module arp_spoof_monitor #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  arpm_pkg::in_item_t  in_data,
  output logic                out_valid,
  output arpm_pkg::out_item_t out_data
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  arpm_pkg::in_item_t  item_r, item_nxt;
  logic [CW-1:0]       addr_r, addr_nxt;       // next entry to read
  logic                pend_r, pend_nxt;       // read data returns this cycle
  logic [AW-1:0]       pend_idx_r, pend_idx_nxt;
  logic [CW-1:0]       used_r, used_nxt;       // fill count of the table
  logic                out_valid_r, out_valid_nxt;
  arpm_pkg::out_item_t out_data_r, out_data_nxt;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  arpm_pkg::entry_t    wr_entry;
  logic                rd_en;
  arpm_pkg::entry_t    rd_entry;
  logic                issue;
  logic                hit;

  arpm_ram #(
    .WIDTH (arpm_pkg::ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (addr_r[AW-1:0]),
    .rd_data (rd_entry)
  );

  // Keep reading while live entries remain; compare the one read last cycle.
  assign issue = (addr_r < used_r);
  assign hit   = pend_r && (rd_entry.ip == item_r.sender_ip);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    addr_nxt      = addr_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    used_nxt      = used_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = pend_idx_r;
    wr_entry.ip   = item_r.sender_ip;
    wr_entry.mac  = item_r.sender_mac;
    rd_en         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt = in_data;
          if (in_data.eth_type == arpm_pkg::ETHERTYPE_ARP &&
              in_data.arp_opcode == arpm_pkg::ARP_OP_REPLY) begin
            // Start a scan from the first entry.
            state_nxt = ST_SCAN;
            addr_nxt  = '0;
          end else begin
            // Drop anything but an ARP reply with an all-zero result.
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
          end
        end
      end

      ST_SCAN: begin
        rd_en        = issue;
        pend_nxt     = issue;
        pend_idx_nxt = addr_r[AW-1:0];
        if (issue) begin
          addr_nxt = addr_r + 1'b1;
        end

        if (hit) begin
          // Known IP: rebind and alert when the MAC moved.
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          if (rd_entry.mac != item_r.sender_mac) begin
            wr_en                     = 1'b1;
            wr_addr                   = pend_idx_r;
            out_data_nxt.spoof_alert  = 1'b1;
            out_data_nxt.previous_mac = rd_entry.mac;
          end
          state_nxt = ST_IDLE;
        end else if (!issue) begin
          // Last live entry compared without a match: learn or drop.
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          if (used_r != FULL_COUNT) begin
            wr_en                    = 1'b1;
            wr_addr                  = used_r[AW-1:0];
            used_nxt                 = used_r + 1'b1;
            out_data_nxt.learned_new = 1'b1;
          end else begin
            out_data_nxt.table_full_drop = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and scan pointers.
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    addr_r     <= addr_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for arp_spoof_monitor. Frame summaries go in through
// the start/busy command port. A scoreboard keeps its own IP-to-MAC binding
// table and predicts the verdict for each accepted transaction. Every out_valid
// strobe is checked against the oldest pending verdict. Stimulus opens with
// hand-picked frames, then moves to weighted random traffic: rebinds, repeats,
// new bindings, table-full drops and non-reply noise.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TABLE_ENTRIES   = 64;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam int REPLY_ITEMS     = 1700;          // ARP replies in the random part
  localparam int CALM_TAIL       = 250;           // last replies sent with no idling
  localparam int SETTLE_CYCLES   = TABLE_ENTRIES + 8;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int MAX_PRINTS      = 60;

  // Scoreboard: owns the predicted binding table and the verdicts still due.
  class binding_scoreboard;
    logic [31:0]         bound_ip  [TABLE_ENTRIES];
    logic [47:0]         bound_mac [TABLE_ENTRIES];
    int                  bound_cnt = 0;
    int                  errors = 0;
    arpm_pkg::out_item_t verdicts_due [$];

    task report(string msg);
      if (errors < MAX_PRINTS) $display("tb_top: mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    function int pending();
      return verdicts_due.size();
    endfunction

    // Work out the verdict for one accepted frame and advance the table.
    function void note_frame(arpm_pkg::in_item_t f);
      arpm_pkg::out_item_t v;
      int                  hit;
      v   = '0;
      hit = -1;
      if (f.eth_type == arpm_pkg::ETHERTYPE_ARP &&
          f.arp_opcode == arpm_pkg::ARP_OP_REPLY) begin
        for (int i = 0; i < bound_cnt; i++) begin
          if (hit < 0 && bound_ip[i] == f.sender_ip) hit = i;
        end
        if (hit >= 0) begin
          if (bound_mac[hit] != f.sender_mac) begin
            v.spoof_alert  = 1'b1;
            v.previous_mac = bound_mac[hit];
            bound_mac[hit] = f.sender_mac;
          end
        end else if (bound_cnt < TABLE_ENTRIES) begin
          bound_ip[bound_cnt]  = f.sender_ip;
          bound_mac[bound_cnt] = f.sender_mac;
          bound_cnt++;
          v.learned_new = 1'b1;
        end else begin
          v.table_full_drop = 1'b1;
        end
      end
      verdicts_due.push_back(v);
    endfunction

    task check_verdict(arpm_pkg::out_item_t got);
      arpm_pkg::out_item_t want;
      if (verdicts_due.size() == 0) begin
        report($sformatf("result with nothing pending: %h", got));
        return;
      end
      want = verdicts_due.pop_front();
      if (got.spoof_alert !== want.spoof_alert)
        report($sformatf("spoof_alert %b, want %b", got.spoof_alert, want.spoof_alert));
      if (got.previous_mac !== want.previous_mac)
        report($sformatf("previous_mac %h, want %h", got.previous_mac, want.previous_mac));
      if (got.learned_new !== want.learned_new)
        report($sformatf("learned_new %b, want %b", got.learned_new, want.learned_new));
      if (got.table_full_drop !== want.table_full_drop)
        report($sformatf("table_full_drop %b, want %b",
                         got.table_full_drop, want.table_full_drop));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                out_valid;
  arpm_pkg::in_item_t  in_data;
  arpm_pkg::out_item_t out_data;

  binding_scoreboard sb = new();
  int unsigned       cycle_cnt = 0;

  arp_spoof_monitor #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every strobed result; the receiver cannot stall, so take it as it comes.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_verdict(out_data);
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic arpm_pkg::in_item_t arp_frame(logic [15:0] et, logic [15:0] op,
                                                   logic [31:0] ip, logic [47:0] mac);
    arpm_pkg::in_item_t f;
    f.eth_type   = et;
    f.arp_opcode = op;
    f.sender_ip  = ip;
    f.sender_mac = mac;
    return f;
  endfunction

  function automatic logic [47:0] rand_mac();
    return 48'({$urandom, $urandom});
  endfunction

  // Pick a frame, mostly ARP replies aimed at the current table contents.
  function automatic arpm_pkg::in_item_t random_frame();
    arpm_pkg::in_item_t f;
    int unsigned        pick;
    int unsigned        idx;
    pick = $urandom_range(0, 99);
    idx  = (sb.bound_cnt != 0) ? $urandom_range(0, sb.bound_cnt - 1) : 0;
    f    = arp_frame(arpm_pkg::ETHERTYPE_ARP, arpm_pkg::ARP_OP_REPLY, $urandom, rand_mac());
    if (pick < 12) begin
      // Noise: a non-reply ARP, a reply opcode on another ethertype, or garbage.
      case (pick % 3)
        0: begin
          f.arp_opcode = 16'($urandom);
          if (f.arp_opcode == arpm_pkg::ARP_OP_REPLY) f.arp_opcode = ARP_OP_REQUEST;
        end
        1: begin
          f.eth_type = 16'($urandom);
          if (f.eth_type == arpm_pkg::ETHERTYPE_ARP) f.eth_type = ETHERTYPE_IPV4;
        end
        default: begin
          f.eth_type   = 16'($urandom);
          f.arp_opcode = 16'($urandom);
        end
      endcase
      // Aim half of it at bound IPs: it must leave their bindings alone.
      if (sb.bound_cnt != 0 && $urandom_range(0, 1) == 1) f.sender_ip = sb.bound_ip[idx];
    end else if (sb.bound_cnt == 0 || pick >= 70) begin
      // Unknown IP: fully random, or one bit away from a bound one.
      if (sb.bound_cnt != 0 && $urandom_range(0, 2) == 0)
        f.sender_ip = sb.bound_ip[idx] ^ (32'd1 << $urandom_range(0, 31));
    end else begin
      // Known IP: same MAC, a random new MAC, or one MAC bit flipped.
      f.sender_ip = sb.bound_ip[idx];
      if (pick < 40) f.sender_mac = sb.bound_mac[idx];
      else if ($urandom_range(0, 1) == 1)
        f.sender_mac = sb.bound_mac[idx] ^ (48'd1 << $urandom_range(0, 47));
    end
    return f;
  endfunction

  // Present one transaction at the falling edge and hold it until taken.
  task automatic send_frame(arpm_pkg::in_item_t f);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= f;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_frame(f);
  endtask

  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Drop start and wait until every pending verdict has been checked.
  task automatic drain_results(int settle);
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    arpm_pkg::in_item_t f;
    arpm_pkg::in_item_t directed [$];
    int                 replies;
    int                 k;

    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Frames the block must ignore, including near misses on the ARP codes.
    directed.push_back(arp_frame(ETHERTYPE_IPV4, arpm_pkg::ARP_OP_REPLY,
                                 32'h0A00_0001, 48'h0200_0000_0001));
    directed.push_back(arp_frame(arpm_pkg::ETHERTYPE_ARP, ARP_OP_REQUEST,
                                 32'h0A00_0001, 48'h0200_0000_0001));
    directed.push_back(arp_frame('1, '1, '1, '1));
    directed.push_back(arp_frame('0, '0, '0, '0));
    directed.push_back(arp_frame(arpm_pkg::ETHERTYPE_ARP ^ 16'h8000,
                                 arpm_pkg::ARP_OP_REPLY, '0, '0));
    directed.push_back(arp_frame(arpm_pkg::ETHERTYPE_ARP,
                                 arpm_pkg::ARP_OP_REPLY ^ 16'h8000, '0, '0));
    // Learn at the address extremes, repeat, then rebind both ways.
    directed.push_back(arp_frame(arpm_pkg::ETHERTYPE_ARP, arpm_pkg::ARP_OP_REPLY, '0, '0));
    directed.push_back(arp_frame(arpm_pkg::ETHERTYPE_ARP, arpm_pkg::ARP_OP_REPLY, '1, '1));
    directed.push_back(arp_frame(arpm_pkg::ETHERTYPE_ARP, arpm_pkg::ARP_OP_REPLY, '0, '0));
    directed.push_back(arp_frame(arpm_pkg::ETHERTYPE_ARP, arpm_pkg::ARP_OP_REPLY, '0, '1));
    directed.push_back(arp_frame(arpm_pkg::ETHERTYPE_ARP, arpm_pkg::ARP_OP_REPLY, '1, '0));
    directed.push_back(arp_frame(arpm_pkg::ETHERTYPE_ARP, arpm_pkg::ARP_OP_REPLY,
                                 '0, 48'h1));
    // A request from a bound IP with another MAC must not rebind it.
    directed.push_back(arp_frame(arpm_pkg::ETHERTYPE_ARP, ARP_OP_REQUEST, '0, 48'h5));
    directed.push_back(arp_frame(arpm_pkg::ETHERTYPE_ARP, arpm_pkg::ARP_OP_REPLY,
                                 '0, 48'h1));
    // Neighboring IPs sharing a MAC are separate bindings.
    directed.push_back(arp_frame(arpm_pkg::ETHERTYPE_ARP, arpm_pkg::ARP_OP_REPLY,
                                 32'h0A00_0001, 48'h0200_0000_0001));
    directed.push_back(arp_frame(arpm_pkg::ETHERTYPE_ARP, arpm_pkg::ARP_OP_REPLY,
                                 32'h0A00_0101, 48'h0200_0000_0001));
    directed.push_back(arp_frame(arpm_pkg::ETHERTYPE_ARP, arpm_pkg::ARP_OP_REPLY,
                                 32'h0A00_0001, 48'h0200_0000_0001));
    directed.push_back(arp_frame(arpm_pkg::ETHERTYPE_ARP, arpm_pkg::ARP_OP_REPLY,
                                 32'h0A00_0101, 48'h0200_0000_0002));
    directed.push_back(arp_frame(arpm_pkg::ETHERTYPE_ARP, arpm_pkg::ARP_OP_REPLY, '1, '0));

    foreach (directed[i]) begin
      if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 12));
      send_frame(directed[i]);
    end
    // Hold off until the directed part has fully drained.
    drain_results(2);

    // Random part: counts ARP replies only, so noise comes on top.
    replies = 0;
    k       = 0;
    while (replies < REPLY_ITEMS) begin
      f = random_frame();
      if (f.eth_type == arpm_pkg::ETHERTYPE_ARP && f.arp_opcode == arpm_pkg::ARP_OP_REPLY)
        replies++;
      // Idle in alternating stretches of about 150 transactions; none in the tail.
      if (replies < REPLY_ITEMS - CALM_TAIL && (k / 150) % 2 == 0 && $urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 12));
      if (replies < REPLY_ITEMS - CALM_TAIL && k % 600 == 599) drain_results(2);
      send_frame(f);
      k++;
    end

    drain_results(SETTLE_CYCLES);
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/arpm_pkg.sv
rtl/core/arpm_ram.sv
rtl/core/arp_spoof_monitor.sv
tb/tb_top.sv
